// ===== rtl/nopr_pkg.sv =====
// Shared constants, codes and types of the note on/off pairing ring.
`default_nettype none

package nopr_pkg;

    // Default geometry
    localparam int unsigned RING_DEPTH_DEF = 4096;
    localparam int unsigned KEY_SLOTS_DEF  = 32768;

    // MIDI status high nibbles
    localparam logic [3:0]  STATUS_ON_HI   = 4'h9;
    localparam logic [3:0]  STATUS_OFF_HI  = 4'h8;

    // Limits
    localparam logic [31:0] CULL_OCCUPANCY = 32'd262144;
    localparam logic [16:0] SPAN_LIMIT     = 17'd65535;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [15:0] SPAN_RESET     = 16'd4000;
    localparam logic [31:0] POS_RESET      = 32'd1;

    // Word widths on the stream ports
    localparam int unsigned IN_DATA_W  = 96;
    localparam int unsigned OUT_DATA_W = 144;

    // Configuration register indexes
    localparam logic CFG_CULL_ENABLE = 1'b0;
    localparam logic CFG_CULL_SPAN   = 1'b1;

    typedef enum logic [1:0] {
        OP_EVENT   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_OPENED     = 3'd1,
        ACT_COUNT_UP   = 3'd2,
        ACT_COUNT_DOWN = 3'd3,
        ACT_CLOSED     = 3'd4,
        ACT_DONE       = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_KEY,
        ST_RING,
        ST_ADV_RD,
        ST_ADV_CHK,
        ST_RESULT
    } state_t;

    // Key table commands
    typedef struct packed {
        logic rd;
        logic wr;
        logic sweep;
    } key_cmd_t;

    // Ring store commands
    typedef struct packed {
        logic rd;
        logic wr_rec;
        logic wr_end;
    } ring_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/nopr_key_table.sv =====
// Per-slot open count and open position memory with its clearing sweep.
`default_nettype none

module nopr_key_table #(
    parameter int unsigned KEY_SLOTS = nopr_pkg::KEY_SLOTS_DEF,
    localparam int unsigned KW = $clog2(KEY_SLOTS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nopr_pkg::key_cmd_t cmd,
    input  wire logic [KW-1:0]      addr,
    input  wire logic [15:0]        wr_count,
    input  wire logic [31:0]        wr_pos,
    output logic      [15:0]        rd_count,
    output logic      [31:0]        rd_pos,
    output logic                    busy
);
    import nopr_pkg::*;

    logic [47:0] mem [KEY_SLOTS];
    logic [47:0] rd_data_reg;
    logic [KW:0] sweep_reg;

    // sweep runs until the counter reaches KEY_SLOTS
    assign busy = ~sweep_reg[KW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_reg <= '0;
        end
        else if (busy)
        begin
            sweep_reg <= sweep_reg + 1'b1;
        end
    end

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            mem[sweep_reg[KW-1:0]] <= '0;
        end
        else if (cmd.wr)
        begin
            mem[addr] <= {wr_count, wr_pos};
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_count = rd_data_reg[47:32];
    assign rd_pos   = rd_data_reg[31:0];

endmodule

`default_nettype wire

// ===== rtl/nopr_ring_store.sv =====
// Note record ring: start tick, end tick and info fields sharing one address.
`default_nettype none

module nopr_ring_store #(
    parameter int unsigned RING_DEPTH = nopr_pkg::RING_DEPTH_DEF,
    localparam int unsigned RW = $clog2(RING_DEPTH)
) (
    input  wire logic                clk,
    input  wire nopr_pkg::ring_cmd_t cmd,
    input  wire logic [RW-1:0]       addr,
    input  wire logic [30:0]         wr_start,
    input  wire logic [30:0]         wr_end,
    input  wire logic [22:0]         wr_info,
    output logic      [30:0]         rd_start,
    output logic      [30:0]         rd_end,
    output logic      [22:0]         rd_info
);
    import nopr_pkg::*;

    logic [30:0] start_mem [RING_DEPTH];
    logic [30:0] end_mem   [RING_DEPTH];
    logic [22:0] info_mem  [RING_DEPTH];

    // field-masked write, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_rec)
        begin
            start_mem[addr] <= wr_start;
            info_mem[addr]  <= wr_info;
        end
        if (cmd.wr_rec || cmd.wr_end)
        begin
            end_mem[addr] <= wr_end;
        end
        if (cmd.rd)
        begin
            rd_start <= start_mem[addr];
            rd_end   <= end_mem[addr];
            rd_info  <= info_mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/note_on_off_pairing_ring_top.sv =====
// Note on/off pairing ring: control sequencer, registers and stream ports.
// Note-on/off words read the key table, then write or read the ring record where one
// is affected, then report; a tail advance reads and checks ring records from the tail
// until it stops; a clear sweeps the key table. Other status and unused opcodes report
// directly. One word at a time; a new word is taken only in the idle state.
// After reset the key table is swept, one slot a cycle, through all KEY_SLOTS slots
// before the first word is taken; configuration writes are taken throughout.
`default_nettype none

module note_on_off_pairing_ring_top #(
    parameter int unsigned RING_DEPTH = nopr_pkg::RING_DEPTH_DEF,
    parameter int unsigned KEY_SLOTS  = nopr_pkg::KEY_SLOTS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input words
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // status[7:0] key[14:8] velocity[22:15] track[30:23] tick[61:31] view[92:62]
    input  wire logic [nopr_pkg::IN_DATA_W-1:0]      s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]                          s_tuser,
    // result words
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // slot[11:0] start[42:12] end[73:43] color[81:74] key[88:82] velocity[96:89]
    // occupancy[109:97] tail[140:110]
    output logic      [nopr_pkg::OUT_DATA_W-1:0]     m_tdata,
    // action[2:0]
    output logic      [2:0]                          m_tuser,
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [15:0]                         cfg_data
);
    import nopr_pkg::*;

    localparam int unsigned RW  = $clog2(RING_DEPTH);
    localparam int unsigned KW  = $clog2(KEY_SLOTS);
    localparam int unsigned OCW = $clog2(RING_DEPTH + 1);
    localparam logic [31:0] DEPTH32 = 32'(RING_DEPTH);

    state_t      state_reg, state_next;
    opcode_t     op_in;
    logic        on_reg, on_next;
    logic        close_reg, close_next;
    logic        cull_reg, cull_next;
    logic        sweep_res_reg, sweep_res_next;
    logic [16:0] thresh_reg, thresh_next;
    logic [30:0] tick_reg, tick_next;
    logic [30:0] view_reg, view_next;
    logic [7:0]  color_reg, color_next;
    logic [6:0]  key_reg, key_next;
    logic [7:0]  vel_reg, vel_next;
    logic [KW-1:0] slot_reg, slot_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] head_reg, head_next;
    logic [31:0] tail_reg, tail_next;
    logic [OCW-1:0] last_occ_reg, last_occ_next;
    logic        cull_en_reg, cull_en_next;
    logic [15:0] span_reg, span_next;
    action_t     act_reg, act_next;
    logic [11:0] rslot_reg, rslot_next;
    logic [30:0] rstart_reg, rstart_next;
    logic [30:0] rend_reg, rend_next;
    logic [22:0] rinfo_reg, rinfo_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [2:0]  m_tuser_reg, m_tuser_next;

    key_cmd_t    key_cmd;
    logic [KW-1:0] key_addr;
    logic [15:0] key_wr_count;
    logic [31:0] key_wr_pos;
    logic [15:0] key_rd_count;
    logic [31:0] key_rd_pos;
    logic        key_busy;

    ring_cmd_t   ring_cmd;
    logic [RW-1:0] ring_addr;
    logic [30:0] ring_wr_start;
    logic [30:0] ring_wr_end;
    logic [22:0] ring_wr_info;
    logic [30:0] ring_rd_start;
    logic [30:0] ring_rd_end;
    logic [22:0] ring_rd_info;

    // input field views
    logic [7:0]  in_status;
    logic [7:0]  in_color;
    logic [14:0] in_slot_full;
    logic [31:0] occ_full;
    logic [31:0] head_dist;
    logic [31:0] pos_ext;
    logic [31:0] tail_step;
    logic [31:0] cull_sum;
    logic [16:0] span_x2;
    logic        skip;

    assign op_in        = opcode_t'(s_tuser);
    assign in_status    = s_tdata[7:0];
    assign in_color     = s_tdata[30:23] | {4'h0, in_status[3:0]};
    assign in_slot_full = {in_color, s_tdata[14:8]};
    assign occ_full     = head_reg - tail_reg;
    assign span_x2      = {span_reg, 1'b0};
    assign cull_sum     = {1'b0, ring_rd_start} + {15'h0, thresh_reg};
    assign skip = ((ring_rd_end != '0) && (ring_rd_end < view_reg)) ||
                  (cull_reg && (cull_sum < {1'b0, view_reg}));

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    nopr_key_table #(.KEY_SLOTS(KEY_SLOTS)) u_key_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (key_cmd),
        .addr     (key_addr),
        .wr_count (key_wr_count),
        .wr_pos   (key_wr_pos),
        .rd_count (key_rd_count),
        .rd_pos   (key_rd_pos),
        .busy     (key_busy)
    );

    nopr_ring_store #(.RING_DEPTH(RING_DEPTH)) u_ring_store (
        .clk      (clk),
        .cmd      (ring_cmd),
        .addr     (ring_addr),
        .wr_start (ring_wr_start),
        .wr_end   (ring_wr_end),
        .wr_info  (ring_wr_info),
        .rd_start (ring_rd_start),
        .rd_end   (ring_rd_end),
        .rd_info  (ring_rd_info)
    );

    // state register and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_res_reg <= 1'b0;
            head_reg      <= POS_RESET;
            tail_reg      <= POS_RESET;
            last_occ_reg  <= '0;
            cull_en_reg   <= 1'b0;
            span_reg      <= SPAN_RESET;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_res_reg <= sweep_res_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            last_occ_reg  <= last_occ_next;
            cull_en_reg   <= cull_en_next;
            span_reg      <= span_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        on_reg      <= on_next;
        close_reg   <= close_next;
        cull_reg    <= cull_next;
        thresh_reg  <= thresh_next;
        tick_reg    <= tick_next;
        view_reg    <= view_next;
        color_reg   <= color_next;
        key_reg     <= key_next;
        vel_reg     <= vel_next;
        slot_reg    <= slot_next;
        pos_reg     <= pos_next;
        act_reg     <= act_next;
        rslot_reg   <= rslot_next;
        rstart_reg  <= rstart_next;
        rend_reg    <= rend_next;
        rinfo_reg   <= rinfo_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // next state, memory commands and result assembly
    always_comb
    begin
        state_next     = state_reg;
        sweep_res_next = sweep_res_reg;
        on_next        = on_reg;
        close_next     = close_reg;
        cull_next      = cull_reg;
        thresh_next    = thresh_reg;
        tick_next      = tick_reg;
        view_next      = view_reg;
        color_next     = color_reg;
        key_next       = key_reg;
        vel_next       = vel_reg;
        slot_next      = slot_reg;
        pos_next       = pos_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        last_occ_next  = last_occ_reg;
        cull_en_next   = cull_en_reg;
        span_next      = span_reg;
        act_next       = act_reg;
        rslot_next     = rslot_reg;
        rstart_next    = rstart_reg;
        rend_next      = rend_reg;
        rinfo_next     = rinfo_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tvalid_next  = m_tvalid_reg;

        key_cmd        = '0;
        key_addr       = slot_reg;
        key_wr_count   = key_rd_count;
        key_wr_pos     = key_rd_pos;
        ring_cmd       = '0;
        ring_addr      = pos_reg[RW-1:0];
        ring_wr_start  = tick_reg;
        ring_wr_end    = tick_reg;
        ring_wr_info   = {color_reg, key_reg, vel_reg};
        head_dist      = head_reg - key_rd_pos;
        pos_ext        = '0;
        tail_step      = tail_reg + 32'd1;

        // result word taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CULL_ENABLE: cull_en_next = cfg_data[0];
                CFG_CULL_SPAN:   span_next    = cfg_data;
                default:         span_next    = span_reg;
            endcase
        end

        unique case (state_reg)
            ST_SWEEP:
            begin
                if (!key_busy)
                begin
                    state_next     = sweep_res_reg ? ST_RESULT : ST_IDLE;
                    sweep_res_next = 1'b0;
                end
            end

            ST_IDLE:
            begin
                tick_next   = s_tdata[61:31];
                view_next   = s_tdata[92:62];
                color_next  = in_color;
                key_next    = s_tdata[14:8];
                vel_next    = s_tdata[22:15];
                slot_next   = in_slot_full[KW-1:0];
                on_next     = (in_status[7:4] == STATUS_ON_HI);
                close_next  = 1'b0;
                rslot_next  = '0;
                rstart_next = '0;
                rend_next   = '0;
                rinfo_next  = '0;
                key_addr    = in_slot_full[KW-1:0];
                if (s_tvalid)
                begin
                    unique case (op_in)
                        OP_EVENT:
                        begin
                            act_next = ACT_NONE;
                            if (in_status[7:4] == STATUS_ON_HI ||
                                in_status[7:4] == STATUS_OFF_HI)
                            begin
                                key_cmd.rd = 1'b1;
                                state_next = ST_KEY;
                            end
                            else
                            begin
                                state_next = ST_RESULT;
                            end
                        end
                        OP_ADVANCE:
                        begin
                            act_next    = ACT_DONE;
                            thresh_next = (span_x2 > SPAN_LIMIT) ? SPAN_LIMIT : span_x2;
                            cull_next   = cull_en_reg &&
                                          (32'(last_occ_reg) > CULL_OCCUPANCY);
                            if (occ_full > DEPTH32)
                            begin
                                tail_next = head_reg - DEPTH32;
                            end
                            state_next  = ST_ADV_RD;
                        end
                        OP_CLEAR:
                        begin
                            act_next       = ACT_DONE;
                            head_next      = POS_RESET;
                            tail_next      = POS_RESET;
                            key_cmd.sweep  = 1'b1;
                            sweep_res_next = 1'b1;
                            state_next     = ST_SWEEP;
                        end
                        default:
                        begin
                            act_next   = ACT_NONE;
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_KEY:
            begin
                pos_next  = key_rd_pos;
                ring_addr = key_rd_pos[RW-1:0];
                if (on_reg)
                begin
                    if (key_rd_count == '0)
                    begin
                        // first note-on: append at the head
                        key_cmd.wr      = 1'b1;
                        key_wr_count    = 16'd1;
                        key_wr_pos      = head_reg;
                        ring_addr       = head_reg[RW-1:0];
                        ring_cmd.wr_rec = 1'b1;
                        ring_wr_end     = '0;
                        pos_ext         = 32'(head_reg[RW-1:0]);
                        rslot_next      = pos_ext[11:0];
                        rstart_next     = tick_reg;
                        rend_next       = '0;
                        rinfo_next      = {color_reg, key_reg, vel_reg};
                        head_next       = head_reg + 32'd1;
                        act_next        = ACT_OPENED;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        key_cmd.wr   = 1'b1;
                        key_wr_count = (key_rd_count == COUNT_MAX) ?
                                       COUNT_MAX : key_rd_count + 16'd1;
                        ring_cmd.rd  = 1'b1;
                        act_next     = ACT_COUNT_UP;
                        state_next   = ST_RING;
                    end
                end
                else if (key_rd_count == '0)
                begin
                    // unmatched note-off
                    act_next   = ACT_NONE;
                    state_next = ST_RESULT;
                end
                else
                begin
                    key_cmd.wr   = 1'b1;
                    key_wr_count = key_rd_count - 16'd1;
                    if (key_rd_count != 16'd1)
                    begin
                        ring_cmd.rd = 1'b1;
                        act_next    = ACT_COUNT_DOWN;
                        state_next  = ST_RING;
                    end
                    else if (head_dist <= DEPTH32)
                    begin
                        ring_cmd.rd = 1'b1;
                        close_next  = 1'b1;
                        act_next    = ACT_CLOSED;
                        state_next  = ST_RING;
                    end
                    else
                    begin
                        // record already overrun: report slot only
                        pos_ext    = 32'(key_rd_pos[RW-1:0]);
                        rslot_next = pos_ext[11:0];
                        act_next   = ACT_CLOSED;
                        state_next = ST_RESULT;
                    end
                end
            end

            ST_RING:
            begin
                pos_ext     = 32'(pos_reg[RW-1:0]);
                rslot_next  = pos_ext[11:0];
                rstart_next = ring_rd_start;
                rend_next   = close_reg ? tick_reg : ring_rd_end;
                rinfo_next  = ring_rd_info;
                if (close_reg)
                begin
                    ring_cmd.wr_end = 1'b1;
                end
                state_next  = ST_RESULT;
            end

            ST_ADV_RD:
            begin
                ring_addr = tail_reg[RW-1:0];
                if (tail_reg == head_reg)
                begin
                    last_occ_next = occ_full[OCW-1:0];
                    state_next    = ST_RESULT;
                end
                else
                begin
                    ring_cmd.rd = 1'b1;
                    state_next  = ST_ADV_CHK;
                end
            end

            ST_ADV_CHK:
            begin
                if (skip)
                begin
                    tail_next  = tail_step;
                    state_next = ST_ADV_RD;
                end
                else
                begin
                    last_occ_next = occ_full[OCW-1:0];
                    state_next    = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = act_reg;
                    m_tdata_next  = {3'b000, tail_reg[30:0], occ_full[12:0],
                                     rinfo_reg[7:0], rinfo_reg[14:8], rinfo_reg[22:15],
                                     rend_reg, rstart_reg, rslot_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/nopr_checker.sv =====
// Port-level checks of the pairing ring, bound to the top level.
`default_nettype none

module nopr_checker #(
    parameter int unsigned RING_DEPTH = nopr_pkg::RING_DEPTH_DEF
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [nopr_pkg::OUT_DATA_W-1:0]   m_tdata,
    input wire logic [2:0]                        m_tuser
);
    import nopr_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // no record affected: slot and record fields are zero
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ACT_NONE || m_tuser == ACT_DONE) |->
        m_tdata[96:0] == '0)
        else $error("record fields set without an affected record");

    // a newly opened note is open
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ACT_OPENED |-> m_tdata[73:43] == '0)
        else $error("opened note carries an end tick");

    // after a tail advance or clear the ring never holds more than its depth
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ACT_DONE |-> 32'(m_tdata[109:97]) <= 32'(RING_DEPTH))
        else $error("occupancy beyond ring depth");

    // action code range
    a_act: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= ACT_DONE)
        else $error("undefined action code");

endmodule

bind note_on_off_pairing_ring_top nopr_checker #(.RING_DEPTH(RING_DEPTH)) u_nopr_checker (.*);

`default_nettype wire
